/* rtl/mdp_pkg.sv */
// Shared types, constants and constant functions of the Magnus dew point unit.
package mdp_pkg;

   // Sensor word that marks a missing reading.
   localparam logic [15:0] RAW_MISSING = 16'hFFFF;
   // Raw temperature that stands for zero degrees.
   localparam logic [15:0] T_OFFSET = 16'd400;
   localparam logic signed [16:0] T_OFFSET_S = 17'sd400;

   // Magnus coefficients, scaled by ten (a) and by ten or one thousand (b).
   localparam logic [6:0]  A10_POS  = 7'd75;
   localparam logic [6:0]  A10_NEG  = 7'd76;
   localparam logic [11:0] B10_POS  = 12'd2373;
   localparam logic [11:0] B10_NEG  = 12'd2407;
   localparam logic [17:0] B100_POS = 18'd237300;
   localparam logic [17:0] B100_NEG = 18'd240700;

   // log10(2) with 30 fraction bits.
   localparam int unsigned LOG10_2_Q30 = 323228497;
   // Saturation bound of the dew point in hundredths of a degree.
   localparam logic [13:0] DP_LIMIT = 14'd10000;

   // One classified sample as it travels from the front to the back.
   typedef struct packed {
      logic                bad;
      logic                neg;
      logic signed [16:0]  t10;
      logic [15:0]         h;
   } mdp_item_type;

   // Control bits that ride along the compute pipeline.
   typedef struct packed {
      logic valid;
      logic bad;
      logic neg;
   } mdp_side_type;

   // Flags of the final division stage.
   typedef struct packed {
      logic den_bad;
      logic vneg;
   } mdp_tail_type;

   // Fixed-point log2 of a constant, evaluated at elaboration only.
   function automatic longint unsigned log2_const(input int unsigned h,
                                                  input int frac_bits);
      int                e;
      longint unsigned   x;
      longint unsigned   fr;
      e  = 0;
      fr = 0;
      for (int i = 0; i < 15; i++) begin
         if ((h >> (i + 1)) != 0) begin
            e = i + 1;
         end
      end
      x = 64'(h) << (30 - e);
      for (int i = 0; i < frac_bits; i++) begin
         x  = (x * x) >> 30;
         fr = fr * 2;
         if (x >= (64'd1 << 31)) begin
            fr = fr + 1;
            x  = x >> 1;
         end
      end
      return (64'(e) << frac_bits) + fr;
   endfunction

endpackage

/* rtl/mdp_front.sv */
// Front end: accepts sensor pairs, flags missing data and splits the temperature.
module mdp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [15:0]          req_temperature_raw,
   input  logic [15:0]          req_humidity_raw,
   input  logic                 q_full,
   output logic                 q_push,
   output mdp_pkg::mdp_item_type q_item
);
   import mdp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   mdp_item_type item_ff;
   mdp_item_type item_in;
   logic         accept;
   logic         move;

   // The held item moves on whenever the queue has room.
   assign move     = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign valid_in = accept || (valid_ff && !move);

   // Classify the sample: missing words and zero humidity give no dew point.
   always_comb begin
      item_in.bad = (req_temperature_raw == RAW_MISSING) ||
                    (req_humidity_raw == RAW_MISSING) ||
                    (req_humidity_raw == 16'd0);
      item_in.neg = req_temperature_raw < T_OFFSET;
      item_in.t10 = $signed({1'b0, req_temperature_raw}) - T_OFFSET_S;
      item_in.h   = req_humidity_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign q_push = move;
   assign q_item = item_ff;

endmodule

/* rtl/mdp_queue.sv */
// Two-entry queue that decouples the front end from the compute pipeline.
module mdp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mdp_pkg::mdp_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output mdp_pkg::mdp_item_type head
);
   import mdp_pkg::*;

   mdp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push;
   logic         do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/mdp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module mdp_div #(
   parameter int NW = 41,
   parameter int DW = 21,
   parameter int QB = 20
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quot,
   output logic          ovf
);
   localparam int CW = (NW > DW + QB) ? NW : DW + QB;

   logic [CW-1:0] rem_ff [QB+1];
   logic [DW-1:0] den_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ovf_ff [QB+1];

   // Entry stage: the quotient overflows when it needs more than QB bits.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= CW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= CW'(num) >= (CW'(den) << QB);
      end
   end

   // One trial subtraction per stage, most significant bit first.
   for (genvar k = 1; k <= QB; k++) begin : g_bit
      localparam int B = QB - k;
      logic [CW-1:0] trial;
      logic          ge;
      logic [QB-1:0] q_next;
      assign trial = CW'(den_ff[k-1]) << B;
      assign ge    = rem_ff[k-1] >= trial;

      // Quotient so far with this stage's bit filled in.
      always_comb begin
         q_next    = q_ff[k-1];
         q_next[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]    <= ge ? rem_ff[k-1] - trial : rem_ff[k-1];
            den_ff[k]    <= den_ff[k-1];
            q_ff[k]      <= q_next;
            ovf_ff[k]    <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[QB];
   assign ovf  = ovf_ff[QB];

endmodule

/* rtl/mdp_log2.sv */
// Pipelined log2 of a 16-bit integer by repeated squaring, one fraction bit per stage.
module mdp_log2 #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [15:0]          h,
   output logic [FRAC_BITS+3:0] result
);
   localparam int N = FRAC_BITS;

   logic [3:0]   e_ff  [N+1];
   logic [30:0]  x_ff  [N+1];
   logic [N-1:0] fr_ff [N+1];
   logic [3:0]   e0;

   // Index of the leading one.
   function automatic logic [3:0] lead_one(input logic [15:0] v);
      logic [3:0] r;
      r = '0;
      for (int i = 1; i < 16; i++) begin
         if (v[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

   assign e0 = lead_one(h);

   // Normalize the mantissa into [1,2) with 30 fraction bits.
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0]  <= e0;
         x_ff[0]  <= 31'(h) << (5'd30 - {1'b0, e0});
         fr_ff[0] <= '0;
      end
   end

   // Square, then renormalize; a carry into the integer bit two gives a one bit.
   for (genvar k = 1; k <= N; k++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] sh;
      assign sq = 62'(x_ff[k-1]) * 62'(x_ff[k-1]);
      assign sh = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            e_ff[k]  <= e_ff[k-1];
            x_ff[k]  <= sh[31] ? sh[31:1] : sh[30:0];
            fr_ff[k] <= {fr_ff[k-1][N-2:0], sh[31]};
         end
      end
   end

   assign result = {e_ff[N], fr_ff[N]};

endmodule

/* rtl/mdp_back.sv */
// Back end: fixed-point Magnus dew point pipeline with an output register.
module mdp_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  mdp_pkg::mdp_item_type q_head,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic signed [14:0]    rsp_dew_point,
   output logic                  rsp_valid_res,
   output logic                  rsp_clipped
);
   import mdp_pkg::*;

   localparam int F        = FRAC_BITS;
   localparam int QB1      = F + 4;
   localparam int NW1      = F + 25;
   localparam int DW1      = 21;
   localparam int QB2      = 14;
   localparam int NW2      = F + 24;
   localparam int DW2      = F + 8;
   localparam int SIDE_LEN = F + 27;
   localparam int LG_DLY   = 5;
   localparam logic [F+3:0] LOG2_100 = (F + 4)'(log2_const(32'd100, F));
   localparam logic signed [F+34:0] L10_X = (F + 35)'(LOG10_2_Q30);

   logic adv;
   logic out_valid_ff;
   logic signed [14:0] out_dp_ff;
   logic signed [14:0] out_dp_in;
   logic out_vr_ff, out_vr_in;
   logic out_clip_ff, out_clip_in;

   mdp_item_type s0_ff;
   mdp_side_type side_ff [SIDE_LEN];

   // The whole pipeline moves when the output register is free or being emptied.
   assign adv       = !out_valid_ff || rsp_pop;
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_LEN; i++) begin
            side_ff[i] <= '0;
         end
      end else if (adv) begin
         side_ff[0] <= '{valid: !q_empty, bad: q_head.bad, neg: q_head.neg};
         for (int i = 1; i < SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= q_head;
      end
   end

   // ---- Temperature term a*t/(b+t) ----
   logic [6:0]          a10_s0;
   logic [11:0]         b10_s0;
   logic [16:0]         tmag;
   logic signed [17:0]  bsum;
   logic [22:0]         amag_ff, amag_in;
   logic [19:0]         ad_ff, ad_in;
   logic [NW1-1:0]      n1_ff;
   logic [DW1-1:0]      d1_ff;
   logic [QB1-1:0]      quot1;
   logic                ovf1;
   logic signed [F+4:0] q_ff, q_in;

   always_comb begin
      a10_s0  = s0_ff.neg ? A10_NEG : A10_POS;
      b10_s0  = s0_ff.neg ? B10_NEG : B10_POS;
      tmag    = s0_ff.neg ? 17'(-s0_ff.t10) : 17'(s0_ff.t10);
      bsum    = $signed({6'b0, b10_s0}) + 18'(s0_ff.t10);
      amag_in = 23'(24'(a10_s0) * 24'(tmag));
      ad_in   = 20'(21'(bsum[16:0]) * 21'(10));
   end

   // Scale the numerator and double both sides for round-half-away division.
   always_ff @(posedge clock) begin
      if (adv) begin
         amag_ff <= amag_in;
         ad_ff   <= ad_in;
         n1_ff   <= (NW1'(amag_ff) << (F + 1)) + NW1'(ad_ff);
         d1_ff   <= {ad_ff, 1'b0};
      end
   end

   mdp_div #(.NW(NW1), .DW(DW1), .QB(QB1)) u_div_q (
      .clock (clock),
      .en    (adv),
      .num   (n1_ff),
      .den   (d1_ff),
      .quot  (quot1),
      .ovf   (ovf1)
   );

   // Restore the sign of the temperature term.
   assign q_in = side_ff[F+7].neg ? -$signed({1'b0, quot1}) : $signed({1'b0, quot1});

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff <= q_in;
      end
   end

   // ---- Humidity term log10(RH/100) ----
   logic [F+3:0]         lg_l;
   logic signed [F+4:0]  diff;
   logic signed [F+34:0] prod_ff, prod_in;
   logic [F+34:0]        pmag;
   logic [F+34:0]        pr;
   logic [F+4:0]         lmag;
   logic signed [F+4:0]  lg_ff, lg_in;
   logic signed [F+4:0]  lgd_ff [LG_DLY];

   mdp_log2 #(.FRAC_BITS(F)) u_log2 (
      .clock  (clock),
      .en     (adv),
      .h      (s0_ff.h),
      .result (lg_l)
   );

   always_comb begin
      diff    = $signed({1'b0, lg_l}) - $signed({1'b0, LOG2_100});
      prod_in = (F + 35)'(diff) * L10_X;
      pmag    = prod_ff[F+34] ? (F + 35)'(-prod_ff) : (F + 35)'(prod_ff);
      pr      = pmag + ((F + 35)'(1) << 29);
      lmag    = pr[F+34:30];
      lg_in   = prod_ff[F+34] ? -$signed(lmag) : $signed(lmag);
   end

   // Convert to log10, round, and delay to meet the temperature term.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         lg_ff     <= lg_in;
         lgd_ff[0] <= lg_ff;
         for (int i = 1; i < LG_DLY; i++) begin
            lgd_ff[i] <= lgd_ff[i-1];
         end
      end
   end

   // ---- Dew point b*v/(a-v) ----
   logic signed [F+5:0] v_ff, v_in;
   logic [F+5:0]        vmag;
   logic [6:0]          a10_c;
   logic [17:0]         b100_c;
   logic [F+22:0]       nmag_ff, nmag_in;
   logic signed [F+9:0] a_sh;
   logic signed [F+9:0] v_x;
   logic signed [F+9:0] den2_ff, den2_in;
   logic                vneg_ff;
   logic                den_bad;
   logic [F+6:0]        dpos;
   logic [NW2-1:0]      n2_ff;
   logic [DW2-1:0]      d2_ff;
   mdp_tail_type        tail_ff [QB2+2];
   logic [QB2-1:0]      quot2;
   logic                ovf2;

   always_comb begin
      v_in    = (F + 6)'(q_ff) + (F + 6)'(lgd_ff[LG_DLY-1]);
      a10_c   = side_ff[F+9].neg ? A10_NEG : A10_POS;
      b100_c  = side_ff[F+9].neg ? B100_NEG : B100_POS;
      vmag    = v_ff[F+5] ? (F + 6)'(-v_ff) : (F + 6)'(v_ff);
      nmag_in = (F + 23)'((F + 24)'(b100_c) * (F + 24)'(vmag));
      a_sh    = $signed((F + 10)'(a10_c) << F);
      v_x     = (F + 10)'(v_ff);
      den2_in = a_sh - ((v_x <<< 3) + (v_x <<< 1));
      den_bad = den2_ff[F+9] || (den2_ff == '0);
      dpos    = den_bad ? (F + 7)'(1) : den2_ff[F+6:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff       <= v_in;
         nmag_ff    <= nmag_in;
         den2_ff    <= den2_in;
         vneg_ff    <= v_ff[F+5];
         n2_ff      <= (NW2'(nmag_ff) << 1) + NW2'(dpos);
         d2_ff      <= {dpos, 1'b0};
         tail_ff[0] <= '{den_bad: den_bad, vneg: vneg_ff};
         for (int i = 1; i < QB2 + 2; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
      end
   end

   mdp_div #(.NW(NW2), .DW(DW2), .QB(QB2)) u_div_dp (
      .clock (clock),
      .en    (adv),
      .num   (n2_ff),
      .den   (d2_ff),
      .quot  (quot2),
      .ovf   (ovf2)
   );

   // ---- Saturation and result register ----
   mdp_side_type sd;
   mdp_tail_type td;
   logic [13:0]  mag;

   always_comb begin
      sd          = side_ff[SIDE_LEN-1];
      td          = tail_ff[QB2+1];
      out_vr_in   = !sd.bad;
      out_clip_in = 1'b0;
      mag         = quot2;
      if (sd.bad) begin
         mag = '0;
      end else if (td.den_bad || ovf2 || (quot2 > DP_LIMIT)) begin
         mag         = DP_LIMIT;
         out_clip_in = 1'b1;
      end
      out_dp_in = (td.vneg && !sd.bad) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sd.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_dp_ff   <= out_dp_in;
         out_vr_ff   <= out_vr_in;
         out_clip_ff <= out_clip_in;
      end
   end

   assign rsp_dew_point = out_dp_ff;
   assign rsp_valid_res = out_vr_ff;
   assign rsp_clipped   = out_clip_ff;

   // The temperature quotient always fits its width for a live sample.
   a_q_no_ovf: assert property (@(posedge clock) disable iff (reset)
      side_ff[F+7].valid && !side_ff[F+7].bad |-> !ovf1)
      else $error("temperature term quotient overflowed");

   // A negative v always leaves a positive denominator.
   a_neg_den: assert property (@(posedge clock) disable iff (reset)
      sd.valid && !sd.bad && td.vneg |-> !td.den_bad)
      else $error("non-positive denominator with negative v");

   // A saturated result is always a valid one.
   a_clip_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_clip_ff |-> out_vr_ff)
      else $error("clipped set on an invalid result");

   // The delivered dew point stays within the saturation bounds.
   a_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_dp_ff <= 15'sd10000) && (out_dp_ff >= -15'sd10000))
      else $error("dew point beyond saturation bound");

endmodule

/* rtl/magnus_dew_point_unit.sv */
// Top level of the Magnus dew point unit: front end, queue and compute pipeline.
//
// Usage: the request side is a queue input. A sample transfer happens at a
// rising clock edge with req_push high and req_full low; it carries one raw
// temperature word (tenths of a degree plus 400) and one raw humidity word.
// The result side is a queue output: while rsp_empty is low the oldest result
// is on rsp_dew_point (hundredths of a degree), rsp_valid_res and rsp_clipped,
// and it transfers at an edge with rsp_pop high. Every sample yields exactly
// one result, in order.
// The pipeline holds the log2 squaring chain and two bit-per-stage dividers.
// Throughput is one sample per cycle while the receiver pops every cycle.
// When the receiver stalls, the output register holds and the whole compute
// pipeline freezes; the two-entry queue and the front register then fill
// and req_full rises. Reset empties the queue and all pipeline valid bits;
// no clearing pass is needed.
module magnus_dew_point_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_temperature_raw,
   input  logic [15:0]        req_humidity_raw,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [14:0] rsp_dew_point,
   output logic               rsp_valid_res,
   output logic               rsp_clipped
);
   import mdp_pkg::*;

   logic         q_full;
   logic         q_push;
   mdp_item_type q_item;
   logic         q_empty;
   logic         q_pop;
   mdp_item_type q_head;

   mdp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_temperature_raw (req_temperature_raw),
      .req_humidity_raw    (req_humidity_raw),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (q_item)
   );

   mdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   mdp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_head        (q_head),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_dew_point (rsp_dew_point),
      .rsp_valid_res (rsp_valid_res),
      .rsp_clipped   (rsp_clipped)
   );

endmodule

/* test/magnus_dew_point_unit_tb.sv */
// Testbench of the Magnus dew point unit: queue-driven stimulus with a built-in predictor.
module magnus_dew_point_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mdp_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 29;
   localparam int CYCLE_LIMIT = 400000;

   // One sample, one result.
   typedef struct {
      logic [15:0] temp_raw;
      logic [15:0] hum_raw;
   } sample_type;

   typedef struct {
      logic signed [14:0] dew;
      logic               ok;
      logic               clip;
   } dew_result_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [15:0]        req_temperature_raw;
   logic [15:0]        req_humidity_raw;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [14:0] rsp_dew_point;
   logic               rsp_valid_res;
   logic               rsp_clipped;

   sample_type     pending_samples[$];
   dew_result_type expected_dew[$];
   int             send_idle_pct;
   int             recv_stall_pct;
   int             mismatch_count;
   int             cycle_count;

   magnus_dew_point_unit #(.FRAC_BITS(FRAC)) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_temperature_raw(req_temperature_raw),
      .req_humidity_raw(req_humidity_raw),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_dew_point(rsp_dew_point),
      .rsp_valid_res(rsp_valid_res),
      .rsp_clipped(rsp_clipped)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Quotient rounded half away from zero; the divisor is positive.
   function automatic longint round_div(input longint n, input longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   // Fixed-point base-two logarithm by repeated squaring.
   function automatic longint log2_q(input int unsigned h);
      int              e;
      longint unsigned x;
      longint          fr;
      e = 0;
      fr = 0;
      while (e < 15 && (h >> (e + 1)) != 0) e++;
      x = 64'(h) << (30 - e);
      for (int i = 0; i < FRAC; i++) begin
         x = (x * x) >> 30;
         fr = fr * 2;
         if (x >= (64'd1 << 31)) begin
            fr = fr + 1;
            x = x >> 1;
         end
      end
      return longint'(e) * (longint'(1) << FRAC) + fr;
   endfunction

   // Dew point of one sample.
   function automatic dew_result_type predict_dew(input sample_type s);
      dew_result_type r;
      longint one, t10, a10, b10, q, lg, v, den, dp;
      r.dew = '0;
      r.ok = 1'b0;
      r.clip = 1'b0;
      one = longint'(1) << FRAC;
      if (s.temp_raw == RAW_MISSING || s.hum_raw == RAW_MISSING || s.hum_raw == 16'd0) begin
         return r;
      end
      t10 = longint'(s.temp_raw) - 400;
      if (t10 >= 0) begin
         a10 = 75;
         b10 = 2373;
      end else begin
         a10 = 76;
         b10 = 2407;
      end
      q = round_div(a10 * t10 * one, 10 * (b10 + t10));
      lg = round_div((log2_q(s.hum_raw) - log2_q(100)) * longint'(LOG10_2_Q30),
                     longint'(1) << 30);
      v = q + lg;
      den = a10 * one - 10 * v;
      if (den <= 0) begin
         dp = 10000;
         r.clip = 1'b1;
      end else begin
         dp = round_div(100 * b10 * v, den);
         if (dp > 10000) begin
            dp = 10000;
            r.clip = 1'b1;
         end else if (dp < -10000) begin
            dp = -10000;
            r.clip = 1'b1;
         end
      end
      r.dew = dp[14:0];
      r.ok = 1'b1;
      return r;
   endfunction

   // Driver: offers the next pending sample; a transfer retires it.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         sample_type s;
         bit         sent;
         sent = req_push && !req_full;
         if (sent) begin
            expected_dew.push_back(predict_dew(pending_samples.pop_front()));
         end
         if ((!req_push || sent) && pending_samples.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            s = pending_samples[0];
            req_push <= 1'b1;
            req_temperature_raw <= s.temp_raw;
            req_humidity_raw <= s.hum_raw;
         end else if (sent) begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer and draws the pop for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            dew_result_type e;
            if (expected_dew.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected result %0d", rsp_dew_point);
            end else begin
               e = expected_dew.pop_front();
               if (e.dew !== rsp_dew_point || e.ok !== rsp_valid_res ||
                   e.clip !== rsp_clipped) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch: expected dp=%0d valid=%0b clip=%0b, %s",
                              e.dew, e.ok, e.clip,
                              $sformatf("got dp=%0d valid=%0b clip=%0b",
                                        rsp_dew_point, rsp_valid_res, rsp_clipped));
                  end
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic sample_type mk(input logic [15:0] t, input logic [15:0] h);
      sample_type s;
      s.temp_raw = t;
      s.hum_raw = h;
      return s;
   endfunction

   // Random sample: mostly plausible readings, some full-range noise.
   function automatic sample_type random_sample();
      int k;
      k = $urandom_range(99);
      if (k < 70) return mk(16'($urandom_range(1400)), 16'($urandom_range(100, 1)));
      if (k < 80) return mk(16'($urandom_range(3000)), 16'($urandom_range(255)));
      if (k < 85) return mk(($urandom_range(9) == 0) ? RAW_MISSING : 16'($urandom_range(1400)),
                            ($urandom_range(1) == 0) ? RAW_MISSING : 16'd0);
      return mk(16'($urandom_range(65535)), 16'($urandom_range(65535)));
   endfunction

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_push || expected_dew.size() > 0)
         @(posedge clock);
   endtask

   // Stimulus in phases of idling.
   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 61, 0, 16};
      recv_pct = '{0, 0, 61, 16};
      req_push = 1'b0;
      rsp_pop = 1'b0;
      req_temperature_raw = '0;
      req_humidity_raw = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed samples: extremes, missing words, zero and high humidity, both signs.
      pending_samples.push_back(mk(16'd400, 16'd100));
      pending_samples.push_back(mk(16'd399, 16'd50));
      pending_samples.push_back(mk(16'd0, 16'd1));
      pending_samples.push_back(mk(16'd0, 16'd100));
      pending_samples.push_back(mk(16'd1400, 16'd100));
      pending_samples.push_back(mk(16'd1400, 16'd1));
      pending_samples.push_back(mk(RAW_MISSING, 16'd50));
      pending_samples.push_back(mk(16'd600, RAW_MISSING));
      pending_samples.push_back(mk(RAW_MISSING, RAW_MISSING));
      pending_samples.push_back(mk(16'd600, 16'd0));
      pending_samples.push_back(mk(16'd600, 16'd200));
      pending_samples.push_back(mk(16'd600, 16'hFFFE));
      pending_samples.push_back(mk(16'hFFFE, 16'd100));
      pending_samples.push_back(mk(16'hFFFE, 16'hFFFE));
      pending_samples.push_back(mk(16'h8000, 16'h8000));
      pending_samples.push_back(mk(16'h7FFF, 16'h7FFF));
      pending_samples.push_back(mk(16'd2000, 16'd100));
      pending_samples.push_back(mk(16'd650, 16'd65));
      pending_samples.push_back(mk(16'd200, 16'd80));
      pending_samples.push_back(mk(16'd401, 16'd99));

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         recv_stall_pct = recv_pct[p];
         for (int i = 0; i < 200; i++) pending_samples.push_back(random_sample());
         wait_drained();
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_dew.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
